FILE: src/stv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stv_pkg;

    localparam int DATA_W     = 47;
    localparam int PRIME_W    = 24;
    localparam int OFS_W      = 12;
    localparam int CNT_W      = 13;
    localparam int POS_W      = 25;
    localparam int WINDOW_DEF = 4096;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_APPLY = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic REG_RANGE_START = 1'b0;
    localparam logic REG_RANGE_COUNT = 1'b1;

endpackage

`default_nettype wire

FILE: src/stv_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module stv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: src/stv_div.sv
`timescale 1ns / 1ps
`default_nettype none

module stv_div
    import stv_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] dividend,
    input  wire logic [DATA_W-1:0] divisor,
    output logic                   done,
    output logic      [DATA_W-1:0] quotient,
    output logic      [DATA_W-1:0] remainder
);

    localparam int CW = $clog2(DATA_W + 1);

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] den_reg;
    logic [CW-1:0]     cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    // one quotient bit a cycle, restoring
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DATA_W-1]};
        diff    = shifted - {1'b0, den_reg};
        if (shifted >= {1'b0, den_reg})
        begin
            rem_next = diff[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                rem_reg <= '0;
                quo_reg <= dividend;
                den_reg <= divisor;
            end
            else if (run_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DATA_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

FILE: src/segmented_totient_sieve_top.sv
// channel   signals                                    handshake
// command   start, busy, action, prime, offset         taken when start & !busy
// result    done, totient, read_offset                 one-cycle strobe, no stall
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  written when valid & ready
//
// start action sweeps the whole window, one entry a cycle.
// apply action: one division finds the first multiple when the prime lies below
// range_start, then per visited multiple the entry is read and divided on the
// shared 47-bit divider (one for the totient; for a nonzero residual one per
// factor stripped plus one that ends the strip) and written back.
// read: one division when a residual factor is left; zero outside the window.
// reset clears control only; the stores hold garbage until a start action.
// cfg_ready is always high; results cannot be held off by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module segmented_totient_sieve_top
    import stv_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         action,
    input  wire logic [PRIME_W-1:0] prime,
    input  wire logic [OFS_W-1:0]   offset,
    output logic                    done,
    output logic      [DATA_W-1:0]  totient,
    output logic      [OFS_W-1:0]   read_offset,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [DATA_W-1:0]  cfg_data
);

    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [POS_W-1:0] WIN_LEN  = POS_W'(WINDOW);
    localparam logic [POS_W-1:0] WIN_LAST = POS_W'(WINDOW - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_MOD,
        S_CHECK,
        S_WAIT,
        S_LOAD,
        S_TDIV,
        S_RDIV,
        S_WB,
        S_QWAIT,
        S_QLOAD,
        S_QDIV
    } state_t;

    state_t              state_reg;
    logic [DATA_W-1:0]   range_start_reg;
    logic [CNT_W-1:0]    range_count_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [DATA_W-1:0]   fill_reg;
    logic [PRIME_W-1:0]  p_reg;
    logic [DATA_W-1:0]   t_reg;
    logic [DATA_W-1:0]   r_reg;
    logic                div_start_reg;
    logic [DATA_W-1:0]   div_a_reg;
    logic [DATA_W-1:0]   div_b_reg;
    logic                done_reg;
    logic [DATA_W-1:0]   totient_reg;
    logic [OFS_W-1:0]    read_offset_reg;

    logic [POS_W-1:0]    len;
    logic [DATA_W-1:0]   p_ext;
    logic [DATA_W-1:0]   prime_ext;
    logic                div_done;
    logic [DATA_W-1:0]   div_q;
    logic [DATA_W-1:0]   div_r;
    logic                mem_we;
    logic [AW-1:0]       mem_addr;
    logic [DATA_W-1:0]   res_wdata;
    logic [DATA_W-1:0]   tot_wdata;
    logic [DATA_W-1:0]   res_rdata;
    logic [DATA_W-1:0]   tot_rdata;
    logic [DATA_W-1:0]   scaled;

    assign len = (POS_W'(range_count_reg) > WIN_LEN) ? WIN_LEN : POS_W'(range_count_reg);
    assign p_ext     = DATA_W'(p_reg);
    assign prime_ext = DATA_W'(prime);
    // (t / d) * (d - 1) == t - t % d - t / d
    assign scaled    = t_reg - div_r - div_q;

    assign mem_we    = (state_reg == S_FILL) || (state_reg == S_WB);
    assign mem_addr  = pos_reg[AW-1:0];
    assign res_wdata = (state_reg == S_FILL) ? fill_reg : r_reg;
    assign tot_wdata = (state_reg == S_FILL) ? fill_reg : t_reg;

    stv_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW)
    ) u_res_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_addr),
        .wdata (res_wdata),
        .raddr (mem_addr),
        .rdata (res_rdata)
    );

    stv_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW)
    ) u_tot_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_addr),
        .wdata (tot_wdata),
        .raddr (mem_addr),
        .rdata (tot_rdata)
    );

    stv_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (div_a_reg),
        .divisor   (div_b_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            range_start_reg <= DATA_W'(1);
            range_count_reg <= CNT_W'(1);
            div_start_reg   <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            done_reg      <= 1'b0;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_RANGE_START: range_start_reg <= cfg_data;
                    REG_RANGE_COUNT: range_count_reg <= cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        unique case (action)
                            ACT_START:
                            begin
                                pos_reg   <= '0;
                                fill_reg  <= range_start_reg;
                                state_reg <= S_FILL;
                            end
                            ACT_APPLY:
                            begin
                                p_reg <= prime;
                                if (prime >= PRIME_W'(2) && len != '0)
                                begin
                                    if (prime_ext >= range_start_reg)
                                    begin
                                        pos_reg   <= POS_W'(prime_ext - range_start_reg);
                                        state_reg <= S_CHECK;
                                    end
                                    else
                                    begin
                                        div_a_reg     <= range_start_reg;
                                        div_b_reg     <= prime_ext;
                                        div_start_reg <= 1'b1;
                                        state_reg     <= S_MOD;
                                    end
                                end
                            end
                            ACT_READ:
                            begin
                                read_offset_reg <= offset;
                                if (POS_W'(offset) < len)
                                begin
                                    pos_reg   <= POS_W'(offset);
                                    state_reg <= S_QWAIT;
                                end
                                else
                                begin
                                    totient_reg <= '0;
                                    done_reg    <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                S_FILL:
                begin
                    fill_reg <= fill_reg + 1'b1;
                    pos_reg  <= pos_reg + 1'b1;
                    if (pos_reg == WIN_LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_MOD:
                begin
                    if (div_done)
                    begin
                        // distance from range_start up to the next multiple
                        if (div_r == '0)
                        begin
                            pos_reg <= '0;
                        end
                        else
                        begin
                            pos_reg <= POS_W'(p_ext - div_r);
                        end
                        state_reg <= S_CHECK;
                    end
                end

                S_CHECK:
                begin
                    if (pos_reg >= len)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_WAIT;
                    end
                end

                S_WAIT:
                begin
                    state_reg <= S_LOAD;
                end

                S_LOAD:
                begin
                    t_reg         <= tot_rdata;
                    r_reg         <= res_rdata;
                    div_a_reg     <= tot_rdata;
                    div_b_reg     <= p_ext;
                    div_start_reg <= 1'b1;
                    state_reg     <= S_TDIV;
                end

                S_TDIV:
                begin
                    if (div_done)
                    begin
                        t_reg <= scaled;
                        if (r_reg != '0)
                        begin
                            div_a_reg     <= r_reg;
                            div_b_reg     <= p_ext;
                            div_start_reg <= 1'b1;
                            state_reg     <= S_RDIV;
                        end
                        else
                        begin
                            state_reg <= S_WB;
                        end
                    end
                end

                S_RDIV:
                begin
                    if (div_done)
                    begin
                        // strip one more factor while it divides evenly
                        if (div_r == '0)
                        begin
                            r_reg         <= div_q;
                            div_a_reg     <= div_q;
                            div_start_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_WB;
                        end
                    end
                end

                S_WB:
                begin
                    pos_reg   <= pos_reg + POS_W'(p_reg);
                    state_reg <= S_CHECK;
                end

                S_QWAIT:
                begin
                    state_reg <= S_QLOAD;
                end

                S_QLOAD:
                begin
                    t_reg <= tot_rdata;
                    if (res_rdata > DATA_W'(1))
                    begin
                        div_a_reg     <= tot_rdata;
                        div_b_reg     <= res_rdata;
                        div_start_reg <= 1'b1;
                        state_reg     <= S_QDIV;
                    end
                    else
                    begin
                        totient_reg <= tot_rdata;
                        done_reg    <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end

                S_QDIV:
                begin
                    if (div_done)
                    begin
                        totient_reg <= scaled;
                        done_reg    <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign cfg_ready   = 1'b1;
    assign done        = done_reg;
    assign totient     = totient_reg;
    assign read_offset = read_offset_reg;

endmodule

`default_nettype wire
